### rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types and constants of the LRU tag store.
// ----------------------------------------------------------------------------
package lts_pkg;

   localparam int TAG_W = 32;                     // tag width
   localparam int CNT_W = 7;                      // capacity / occupancy width
   localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

   // per-cycle commands from the controller to every cell of the stack
   typedef struct packed {
      logic lookup;   // latch the compare result against the incoming tag
      logic shift;    // move the neighbor's tag in, if at or below the limit
   } cell_ctrl_type;

endpackage

### rtl/lts_cell.sv
// ----------------------------------------------------------------------------
// lts_cell
// One entry of the recency stack: holds a tag, compares it, takes the
// neighbor's tag on a shift.
// ----------------------------------------------------------------------------
module lts_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 6,
   parameter int CMP_W = 7
) (
   input  logic                       clock,
   input  lts_pkg::cell_ctrl_type     ctrl,
   input  logic [lts_pkg::TAG_W-1:0]  lookup_tag,
   input  logic [CMP_W-1:0]           count,
   input  logic [IDX_W-1:0]           limit,
   input  logic [lts_pkg::TAG_W-1:0]  prev_tag,
   output logic [lts_pkg::TAG_W-1:0]  tag,
   output logic                       match
);
   import lts_pkg::*;

   localparam logic [CMP_W-1:0] POS_CNT = CMP_W'(INDEX);
   localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(INDEX);

   logic [TAG_W-1:0] tag_ff, tag_in;
   logic             match_ff, match_in;

   always_comb begin
      tag_in   = tag_ff;
      match_in = match_ff;
      if (ctrl.lookup) begin
         // entries at or beyond the fill level are never compared
         match_in = (POS_CNT < count) && (tag_ff == lookup_tag);
      end
      if (ctrl.shift && (POS_IDX <= limit)) begin
         tag_in = prev_tag;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      match_ff <= match_in;
   end

   assign tag   = tag_ff;
   assign match = match_ff;

endmodule

### rtl/lru_tag_store.sv
// ----------------------------------------------------------------------------
// lru_tag_store
// Fully associative tag store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Pulse start with a tag while busy is low; the transfer is taken on that
// edge. The result is registered in the decide state and shows on the rsp_
// ports for one cycle, marked by rsp_valid; busy drops as rsp_valid falls,
// and a new tag is taken only when busy is low, so each lookup finishes
// before the next begins. The three steps are compare in every cell (on the
// accepting edge), encode the hit position and pick the shift limit, then
// shift the row of cells. The receiver cannot stall; capture the result when
// rsp_valid is high. Capacity is written through the csr_ channel (always
// ready) and should only change while busy is low. Values of 0 act as 1;
// values above MAX_ENTRIES act as MAX_ENTRIES.
// ----------------------------------------------------------------------------
module lru_tag_store #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   // lookup request
   input  logic                       start,
   output logic                       busy,
   input  logic [lts_pkg::TAG_W-1:0]  req_tag,
   // capacity register
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lts_pkg::CNT_W-1:0]  csr_capacity,
   // result
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic                       rsp_evicted,
   output logic [lts_pkg::TAG_W-1:0]  rsp_evicted_tag,
   output logic [lts_pkg::CNT_W-1:0]  rsp_occupancy
);
   import lts_pkg::*;

   localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CMP_W   = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
   localparam int CAP_MAX = (MAX_ENTRIES < 127) ? MAX_ENTRIES : 127;
   localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(CAP_MAX);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_SHIFT
   } state_type;

   state_type         state_ff;
   logic [TAG_W-1:0]  key_ff;
   logic [CNT_W-1:0]  cap_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  limit_ff;
   logic              rsp_valid_ff, rsp_hit_ff, rsp_evicted_ff;
   logic [TAG_W-1:0]  rsp_ev_tag_ff;

   cell_ctrl_type     ctrl;
   logic [TAG_W-1:0]  cell_tag [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] cell_match;

   logic              accept;
   logic              hit;
   logic              full;
   logic [IDX_W-1:0]  hit_pos;
   logic [CNT_W-1:0]  eff_cap;
   logic [CMP_W-1:0]  count_ext, count_m1;
   logic [IDX_W-1:0]  lim_evict, lim_insert;
   logic [TAG_W-1:0]  lru_tag;

   assign accept      = start && (state_ff == S_IDLE);
   assign ctrl.lookup = accept;
   assign ctrl.shift  = (state_ff == S_SHIFT);

   // ---- row of cells; cell 0 takes the new tag, cell i takes cell i-1 ----
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic [TAG_W-1:0] prev;
      if (g == 0) begin : g_top
         assign prev = key_ff;
      end else begin : g_rest
         assign prev = cell_tag[g-1];
      end
      lts_cell #(
         .INDEX (g),
         .IDX_W (IDX_W),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .lookup_tag (req_tag),
         .count      (count_ext),
         .limit      (limit_ff),
         .prev_tag   (prev),
         .tag        (cell_tag[g]),
         .match      (cell_match[g])
      );
   end

   // ---- hit position: tags are unique, so at most one match bit is set ----
   always_comb begin
      hit_pos = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (cell_match[i]) begin
            hit_pos = hit_pos | IDX_W'(i);
         end
      end
   end

   assign hit = |cell_match;

   // capacity clamp: zero acts as one, saturate at the store size
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (cap_ff > CAP_LIMIT) begin
         eff_cap = CAP_LIMIT;
      end else begin
         eff_cap = cap_ff;
      end
   end

   assign count_ext  = CMP_W'(count_ff);
   assign count_m1   = count_ext - CMP_W'(1);
   assign full       = (count_ff >= eff_cap);
   assign lim_evict  = count_m1[IDX_W-1:0];   // least recent slot
   assign lim_insert = count_ext[IDX_W-1:0];  // first free slot
   assign lru_tag    = cell_tag[lim_evict];

   // ---- controller: state and registered outputs ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            cap_ff <= csr_capacity;
         end
         case (state_ff)
            S_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (start) begin
                  key_ff   <= req_tag;
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               rsp_hit_ff <= hit;
               if (hit) begin
                  limit_ff       <= hit_pos;
                  rsp_evicted_ff <= 1'b0;
                  rsp_ev_tag_ff  <= '0;
               end else if (full) begin
                  // drop the least recent entry, occupancy unchanged
                  limit_ff       <= lim_evict;
                  rsp_evicted_ff <= 1'b1;
                  rsp_ev_tag_ff  <= lru_tag;
               end else begin
                  limit_ff       <= lim_insert;
                  rsp_evicted_ff <= 1'b0;
                  rsp_ev_tag_ff  <= '0;
                  count_ff       <= count_ff + CNT_W'(1);
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_SHIFT;
            end
            S_SHIFT: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_tag = rsp_ev_tag_ff;
   assign rsp_occupancy   = count_ff;

endmodule
